// ===== hw/rtl/spectral_index_with_stats_top_defines.svh =====
// Assertion macros for the spectral index block.
`ifndef SPECTRAL_INDEX_WITH_STATS_TOP_DEFINES_SVH
`define SPECTRAL_INDEX_WITH_STATS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SPIDX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spidx assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SPIDX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spidx assertion failed");

`endif

// ===== hw/rtl/spidx_pkg.sv =====
package spidx_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_W         = 31;
  localparam int unsigned QBITS         = 33;
  localparam int unsigned SQRT_STEPS    = 32;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned IN_W          = 48;
  localparam int unsigned OUT_W         = 200;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;

  typedef enum logic [2:0] {
    REG_INDEX_MODE    = 3'd0,
    REG_NODATA_ENABLE = 3'd1,
    REG_NODATA_BAND1  = 3'd2,
    REG_NODATA_BAND2  = 3'd3,
    REG_NODATA_BAND3  = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    MODE_ND      = 4'd0,
    MODE_RATIO   = 4'd1,
    MODE_DIFF    = 4'd2,
    MODE_PCT     = 4'd3,
    MODE_EVI2    = 4'd4,
    MODE_SAVI    = 4'd5,
    MODE_SQPROD  = 4'd6,
    MODE_BRIGHT  = 4'd7,
    MODE_CHLORO  = 4'd8,
    MODE_WDRVI   = 4'd9,
    MODE_EVI     = 4'd10,
    MODE_GBNDVI  = 4'd11,
    MODE_VARI    = 4'd12,
    MODE_LAI     = 4'd13,
    MODE_NMDI    = 4'd14,
    MODE_UNUSED  = 4'd15
  } mode_e;

  localparam logic [3:0] FIRST_THREE_BAND = MODE_EVI;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_START,
    ST_LOOP,
    ST_ROUND,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic prep1;
    logic prep2;
    logic start;
    logic step;
    logic round;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic use_sqrt;
  } status_t;

  localparam logic signed [63:0] INVALID_INT = -64'sd9999;

  function automatic logic [31:0] inv_value(input int unsigned frac);
    logic [63:0] mag;
    mag = 64'(unsigned'(-INVALID_INT)) << frac;
    if (mag >= 64'h8000_0000) begin
      return 32'h8000_0000;
    end
    return 32'(-mag);
  endfunction

endpackage

// ===== hw/rtl/spidx_ctrl.sv =====
module spidx_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  spidx_pkg::status_t  status_i,
  output spidx_pkg::cmd_t     cmd_o
);

  spidx_pkg::state_e state_q, state_d;
  logic [spidx_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic m_valid_q, m_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spidx_pkg::ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    m_valid_d = m_valid_q && !m_ready_i;
    case (state_q)
      spidx_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = spidx_pkg::ST_PREP1;
        end
      end
      spidx_pkg::ST_PREP1: begin
        cmd_o.prep1 = 1'b1;
        state_d     = spidx_pkg::ST_PREP2;
      end
      spidx_pkg::ST_PREP2: begin
        cmd_o.prep2 = 1'b1;
        state_d     = spidx_pkg::ST_START;
      end
      spidx_pkg::ST_START: begin
        cmd_o.start = 1'b1;
        cnt_d = status_i.use_sqrt ? spidx_pkg::CNT_W'(spidx_pkg::SQRT_STEPS - 1)
                                  : spidx_pkg::CNT_W'(spidx_pkg::QBITS - 1);
        state_d = status_i.ok ? spidx_pkg::ST_LOOP : spidx_pkg::ST_DONE;
      end
      spidx_pkg::ST_LOOP: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = spidx_pkg::ST_ROUND;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      spidx_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = spidx_pkg::ST_DONE;
      end
      spidx_pkg::ST_DONE: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.emit = 1'b1;
          m_valid_d  = 1'b1;
          state_d    = spidx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spidx_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_valid_o = m_valid_q;

endmodule

// ===== hw/rtl/spidx_datapath.sv =====
module spidx_datapath #(
  parameter int unsigned FRAC_BITS = spidx_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spidx_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [spidx_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [spidx_pkg::IN_W-1:0]          in_data_i,
  input  spidx_pkg::cmd_t                     cmd_i,
  output spidx_pkg::status_t                  status_o,
  output logic [spidx_pkg::OUT_W-1:0]         out_data_o
);

  localparam int unsigned NW    = spidx_pkg::NUM_W;
  localparam int unsigned QW    = spidx_pkg::QBITS;
  localparam int unsigned XW    = NW + FRAC_BITS;
  localparam int unsigned HW    = XW - QW;
  localparam int unsigned SQ_SH = 62 - 2 * FRAC_BITS;
  localparam logic [31:0] INV   = spidx_pkg::inv_value(FRAC_BITS);

  // configuration
  logic [3:0]  mode_q;
  logic        nd_en_q;
  logic [15:0] nd1_q, nd2_q, nd3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= spidx_pkg::MODE_ND;
      nd_en_q <= 1'b0;
      nd1_q   <= 16'(spidx_pkg::INVALID_INT);
      nd2_q   <= 16'(spidx_pkg::INVALID_INT);
      nd3_q   <= 16'(spidx_pkg::INVALID_INT);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spidx_pkg::REG_INDEX_MODE:    mode_q  <= cfg_data_i[3:0];
        spidx_pkg::REG_NODATA_ENABLE: nd_en_q <= cfg_data_i[0];
        spidx_pkg::REG_NODATA_BAND1:  nd1_q   <= cfg_data_i;
        spidx_pkg::REG_NODATA_BAND2:  nd2_q   <= cfg_data_i;
        spidx_pkg::REG_NODATA_BAND3:  nd3_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input capture
  logic [15:0] r1, r2, r3;
  logic [14:0] a_q, b_q, c_q;
  logic        nodata_q;
  logic        three;

  assign r1    = in_data_i[15:0];
  assign r2    = in_data_i[31:16];
  assign r3    = in_data_i[47:32];
  assign three = mode_q >= spidx_pkg::FIRST_THREE_BAND;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q      <= r1[15] ? '0 : r1[14:0];
      b_q      <= r2[15] ? '0 : r2[14:0];
      c_q      <= r3[15] ? '0 : r3[14:0];
      nodata_q <= nd_en_q && (r1 == nd1_q || r2 == nd2_q || (three && r3 == nd3_q));
    end
  end

  // first operand stage
  logic signed [31:0] a_s, b_s, c_s;
  logic signed [31:0] sab_q, dab_q, e_q;
  logic [29:0] prod_q;
  logic [30:0] sq_q;

  assign a_s = $signed({17'd0, a_q});
  assign b_s = $signed({17'd0, b_q});
  assign c_s = $signed({17'd0, c_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep1) begin
      sab_q  <= a_s + b_s;
      dab_q  <= a_s - b_s;
      e_q    <= 32'sd2 + 32'sd2 * a_s + 32'sd12 * b_s - 32'sd15 * c_s;
      prod_q <= a_q * b_q;
      sq_q   <= 31'({15'd0, a_q} * {15'd0, a_q}) + 31'({15'd0, b_q} * {15'd0, b_q});
    end
  end

  // per-mode numerator and denominator
  logic signed [31:0] num, den;
  logic               sqrt_sel, mode_ok;
  logic [30:0]        v;
  logic               neg_q, ok_q, sqrt_q;
  logic [NW-1:0]      un_q, ud_q;
  logic [30:0]        v_q;

  always_comb begin
    num      = dab_q;
    den      = sab_q;
    sqrt_sel = 1'b0;
    mode_ok  = 1'b1;
    v        = 31'(prod_q);
    case (mode_q)
      spidx_pkg::MODE_ND: ;
      spidx_pkg::MODE_RATIO:  begin num = a_s; den = b_s; end
      spidx_pkg::MODE_DIFF:   den = 32'sd1;
      spidx_pkg::MODE_PCT:    num = a_s;
      spidx_pkg::MODE_EVI2:   begin
        num = 32'sd12 * dab_q;
        den = 32'sd5 * (sab_q + 32'sd1);
      end
      spidx_pkg::MODE_SAVI:   begin
        num = 32'sd3 * dab_q;
        den = 32'sd2 * sab_q + 32'sd1;
      end
      spidx_pkg::MODE_SQPROD: sqrt_sel = 1'b1;
      spidx_pkg::MODE_BRIGHT: begin sqrt_sel = 1'b1; v = sq_q; end
      spidx_pkg::MODE_CHLORO: den = b_s;
      spidx_pkg::MODE_WDRVI:  begin
        num = a_s - 32'sd5 * b_s;
        den = a_s + 32'sd5 * b_s;
      end
      spidx_pkg::MODE_EVI:    begin num = 32'sd5 * dab_q; den = e_q; end
      spidx_pkg::MODE_GBNDVI: begin num = dab_q - c_s; den = sab_q + c_s; end
      spidx_pkg::MODE_VARI:   den = sab_q + c_s;
      spidx_pkg::MODE_LAI:    begin
        num = 32'sd18090 * dab_q - 32'sd118 * e_q;
        den = 32'sd1000 * e_q;
      end
      spidx_pkg::MODE_NMDI:   begin num = dab_q + c_s; den = sab_q - c_s; end
      default: mode_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep2) begin
      neg_q  <= num[31] != den[31];
      un_q   <= num[31] ? NW'(-num) : NW'(num);
      ud_q   <= den[31] ? NW'(-den) : NW'(den);
      ok_q   <= !nodata_q && mode_ok && (sqrt_sel || den != 32'sd0);
      sqrt_q <= sqrt_sel;
      v_q    <= v;
    end
  end

  assign status_o.ok       = ok_q;
  assign status_o.use_sqrt = sqrt_q;

  // shared iterative unit: restoring divide or digit-by-digit root
  logic [XW-1:0] x;
  logic [HW-1:0] hi;
  logic [31:0]   rem_q, rem2;
  logic [QW-1:0] xlo_q, quo_q;
  logic          ovf_q, big_q, ge;
  logic [63:0]   sx_q, sres_q, sbit_q, t;

  assign x    = XW'(un_q) << FRAC_BITS;
  assign hi   = x[XW-1:QW];
  assign rem2 = {rem_q[30:0], xlo_q[QW-1]};
  assign ge   = rem2 >= 32'(ud_q);
  assign t    = sres_q + sbit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ovf_q  <= NW'(hi) >= ud_q;
      rem_q  <= 32'(hi);
      xlo_q  <= x[QW-1:0];
      quo_q  <= '0;
      big_q  <= (v_q >> SQ_SH) != '0;
      sx_q   <= 64'(v_q) << (2 * FRAC_BITS);
      sres_q <= '0;
      sbit_q <= 64'd1 << 62;
    end else if (cmd_i.step) begin
      if (sqrt_q) begin
        if (sx_q >= t) begin
          sx_q   <= sx_q - t;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end else begin
        rem_q <= ge ? rem2 - 32'(ud_q) : rem2;
        quo_q <= {quo_q[QW-2:0], ge};
        xlo_q <= xlo_q << 1;
      end
    end
  end

  // rounding and saturation
  logic [QW:0]  qm;
  logic         qneg;
  logic [32:0]  sm;
  logic [31:0]  res_div, res_sqrt;
  logic [31:0]  res_q;

  always_comb begin
    qm   = {1'b0, quo_q} + (QW+1)'({rem_q[30:0], 1'b0} >= 32'(ud_q));
    qneg = neg_q && qm != '0;
    if (ovf_q) begin
      res_div = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (!qneg) begin
      res_div = (qm > (QW+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qm[31:0];
    end else begin
      res_div = (qm >= (QW+1)'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : 32'(-qm);
    end
    sm = {1'b0, sres_q[31:0]} + 33'(sx_q > 64'(sres_q[31:0]));
    if (big_q || sm > 33'h0_7FFF_FFFF) begin
      res_sqrt = 32'h7FFF_FFFF;
    end else begin
      res_sqrt = sm[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      res_q <= sqrt_q ? res_sqrt : res_div;
    end
  end

  // running statistics and result register
  logic               seen_q, seen_d;
  logic signed [31:0] min_q, min_d, max_q, max_d, val;
  logic [31:0]        cnt_q, cnt_d;
  logic [63:0]        sum_q, sum_d;
  logic [spidx_pkg::OUT_W-1:0] out_q;

  always_comb begin
    seen_d = seen_q;
    min_d  = min_q;
    max_d  = max_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    val    = ok_q ? $signed(res_q) : $signed(INV);
    if (ok_q) begin
      seen_d = 1'b1;
      min_d  = (!seen_q || val < min_q) ? val : min_q;
      max_d  = (!seen_q || val > max_q) ? val : max_q;
      cnt_d  = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 1'b1;
      sum_d  = sum_q + 64'(val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      min_q  <= '0;
      max_q  <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
    end else if (cmd_i.emit) begin
      seen_q <= seen_d;
      min_q  <= min_d;
      max_q  <= max_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= {7'd0, sum_d, cnt_d, max_d, min_d, ok_q, val};
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/spectral_index_with_stats_top.sv =====
// Spectral index unit with running statistics. One pixel (three signed 16-bit
// band samples) is taken per request; the result is a signed fixed-point index
// with FRAC_BITS fractional bits, plus running min, max, valid count and sum.
// An item passes from acceptance to a ready result through operand preparation,
// the steps of the shared radix-2 divide/root unit (33 quotient steps for
// divide modes, 32 root steps for the square-root modes) and rounding;
// invalid pixels skip the steps and rounding. A new pixel is accepted the cycle
// after the previous result is moved to the output register, which holds it
// until taken. Configuration registers take a write at any time; write them
// only while the block is idle, as a pixel in flight reads them directly.
module spectral_index_with_stats_top #(
  parameter int unsigned FRAC_BITS = spidx_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spidx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [spidx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // band1_sample, band2_sample, band3_sample
  input  logic [spidx_pkg::IN_W-1:0]       s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // index_value, result_valid, running_min, running_max, valid_total,
  // result_sum, zero fill
  output logic [spidx_pkg::OUT_W-1:0]      m_axis_tdata
);

  spidx_pkg::cmd_t    cmd;
  spidx_pkg::status_t status;

  spidx_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  spidx_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== hw/rtl/spidx_checker.sv =====
`include "spectral_index_with_stats_top_defines.svh"

module spidx_checker #(
  parameter int unsigned FRAC_BITS = spidx_pkg::FRAC_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [spidx_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam logic [31:0] INV = spidx_pkg::inv_value(FRAC_BITS);

  `SPIDX_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SPIDX_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SPIDX_ASSERT_NOW(a_invalid_marker, m_axis_tvalid && !m_axis_tdata[32], m_axis_tdata[31:0] == INV)
  `SPIDX_ASSERT_NOW(a_within_range, m_axis_tvalid && m_axis_tdata[32], ($signed(m_axis_tdata[64:33]) <= $signed(m_axis_tdata[31:0])) && ($signed(m_axis_tdata[31:0]) <= $signed(m_axis_tdata[96:65])))

endmodule

bind spectral_index_with_stats_top spidx_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_spidx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
